[src/assert_macros.svh]
// Concurrent check helpers, sampled on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/steq_pkg.sv]
package steq_pkg;

    localparam int DEPTH     = 8;
    localparam int ID_BITS   = 8;
    localparam int TICK_BITS = 16;

    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 2;
    localparam int PORT_ID_W = 8;
    localparam int CNT_W   = 4;

    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_SCHEDULED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DUE       = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic              load;
        logic              dec;
        logic              pop;
        logic              insert;
        logic              remove_match;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic              last;
    } steq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic head_due;
        logic next_due;
        logic full;
        logic any_match;
    } steq_stat_t;

endpackage

[src/sorted_timer_event_queue_unit.sv]
// A schedule passes through the insert state before its result is registered; a cancel
// first removes the matching entries, one per cycle, then reports. A tick decrements all
// delays, then pops the due events one per cycle with busy high; a tick with no due event
// gives no result. The unit takes no new command while busy.
// Results appear for one cycle on strobe; the receiver cannot stall them.
// Reset (rst_n low, asynchronous) empties the queue and returns to idle.
`include "assert_macros.svh"

module sorted_timer_event_queue_unit
    import steq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     command,
    input  logic [PORT_ID_W-1:0] event_id,
    input  logic [TICK_BITS-1:0] delay_ticks,
    output logic                 strobe,
    output logic [KIND_W-1:0]    kind,
    output logic [PORT_ID_W-1:0] event_id_res,
    output logic [CNT_W-1:0]     removed_count,
    output logic [CNT_W-1:0]     pending_count,
    output logic                 last
);

    steq_cmd_t  cmd;
    steq_stat_t stat;

    steq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    steq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .event_id      (event_id),
        .delay_ticks   (delay_ticks),
        .stat          (stat),
        .strobe        (strobe),
        .kind          (kind),
        .event_id_res  (event_id_res),
        .removed_count (removed_count),
        .pending_count (pending_count),
        .last          (last)
    );

    `CHK_SAME(a_strobe_from_busy, strobe, $past(busy))
    `CHK_SAME(a_pending_bound, strobe, pending_count <= CNT_W'(DEPTH))
    `CHK_NEXT(a_start_goes_busy, start && !busy && command != CMD_UNUSED, busy)
    `CHK_NEXT(a_last_ends_item, strobe && last, !strobe)
    `CHK_SAME(a_one_update, 1'b1, $onehot0({cmd.dec, cmd.pop, cmd.insert, cmd.remove_match}))

endmodule

[src/steq_ctrl.sv]
module steq_ctrl
    import steq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] command,
    input  steq_stat_t       stat,
    output steq_cmd_t        cmd,
    output logic             busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEC    = 3'd1;
    localparam logic [2:0] S_POP    = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_CANCEL = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (command)
                        CMD_TICK:     state_next = S_DEC;
                        CMD_SCHEDULE: state_next = S_INSERT;
                        CMD_CANCEL:   state_next = S_CANCEL;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_DEC:
            begin
                cmd.dec    = 1'b1;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (stat.head_due)
                begin
                    cmd.pop  = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_DUE;
                    cmd.last = !stat.next_due;
                    if (!stat.next_due)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_INSERT:
            begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                if (stat.full)
                begin
                    cmd.kind = KIND_REJECTED;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    cmd.kind   = KIND_SCHEDULED;
                end
                state_next = S_IDLE;
            end
            S_CANCEL:
            begin
                // one matching entry removed per cycle
                if (stat.any_match)
                begin
                    cmd.remove_match = 1'b1;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_CANCELLED;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[src/steq_dp.sv]
module steq_dp
    import steq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  steq_cmd_t            cmd,
    input  logic [PORT_ID_W-1:0] event_id,
    input  logic [TICK_BITS-1:0] delay_ticks,
    output steq_stat_t           stat,
    output logic                 strobe,
    output logic [KIND_W-1:0]    kind,
    output logic [PORT_ID_W-1:0] event_id_res,
    output logic [CNT_W-1:0]     removed_count,
    output logic [CNT_W-1:0]     pending_count,
    output logic                 last
);

    logic [ID_BITS-1:0]   id_reg   [DEPTH];
    logic [ID_BITS-1:0]   id_next  [DEPTH];
    logic [TICK_BITS-1:0] rem_reg  [DEPTH];
    logic [TICK_BITS-1:0] rem_next [DEPTH];
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;
    logic [OCC_W-1:0]     removed_reg;
    logic [ID_BITS-1:0]   lat_id_reg;
    logic [TICK_BITS-1:0] lat_delay_reg;
    logic [TICK_BITS-1:0] adj_delay;

    logic [DEPTH-1:0] valid;
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] from_first;
    logic [DEPTH-1:0] gt;
    logic [DEPTH-2:0] shift_up;
    logic [DEPTH-1:0] shift_down;
    logic [DEPTH-1:0] place;

    logic                 strobe_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [PORT_ID_W-1:0] res_id_reg;
    logic [CNT_W-1:0]     removed_out_reg;
    logic [CNT_W-1:0]     pending_reg;
    logic                 last_reg;

    // one tick off, then at least one tick
    assign adj_delay = (delay_ticks <= TICK_BITS'(1)) ? TICK_BITS'(1)
                                                     : delay_ticks - TICK_BITS'(1);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid[i] = (OCC_W'(i) < occ_reg);
            match[i] = valid[i] && (id_reg[i] == lat_id_reg);
            gt[i]    = valid[i] && (rem_reg[i] > lat_delay_reg);
        end
        from_first[0] = match[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            from_first[i] = from_first[i-1] | match[i];
        end
        shift_down = {gt[DEPTH-2:0], 1'b0};
        for (int i = 0; i < DEPTH; i++)
        begin
            place[i] = !shift_down[i] && (gt[i] || (OCC_W'(i) == occ_reg));
        end
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            shift_up[i] = cmd.pop || (cmd.remove_match && from_first[i]);
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            id_next[i]  = id_reg[i];
            rem_next[i] = rem_reg[i];
        end
        if (cmd.dec)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (rem_reg[i] != '0)
                begin
                    rem_next[i] = rem_reg[i] - TICK_BITS'(1);
                end
            end
        end
        else if (cmd.pop || cmd.remove_match)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (shift_up[i])
                begin
                    id_next[i]  = id_reg[i+1];
                    rem_next[i] = rem_reg[i+1];
                end
            end
            occ_next = occ_reg - OCC_W'(1);
        end
        else if (cmd.insert)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (shift_down[i])
                begin
                    id_next[i]  = id_reg[(i > 0) ? i - 1 : 0];
                    rem_next[i] = rem_reg[(i > 0) ? i - 1 : 0];
                end
                else if (place[i])
                begin
                    id_next[i]  = lat_id_reg;
                    rem_next[i] = lat_delay_reg;
                end
            end
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            id_reg[i]  <= id_next[i];
            rem_reg[i] <= rem_next[i];
        end
        if (cmd.load)
        begin
            lat_id_reg    <= event_id[ID_BITS-1:0];
            lat_delay_reg <= adj_delay;
        end
        if (cmd.emit)
        begin
            kind_reg        <= cmd.kind;
            res_id_reg      <= PORT_ID_W'(cmd.pop ? id_reg[0] : lat_id_reg);
            removed_out_reg <= (cmd.kind == KIND_CANCELLED) ? CNT_W'(removed_reg)
                                                            : '0;
            pending_reg     <= CNT_W'(occ_next);
            last_reg        <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= '0;
            removed_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            occ_reg    <= occ_next;
            strobe_reg <= cmd.emit;
            if (cmd.load)
            begin
                removed_reg <= '0;
            end
            else if (cmd.remove_match)
            begin
                removed_reg <= removed_reg + OCC_W'(1);
            end
        end
    end

    assign stat.head_due  = (occ_reg != '0) && (rem_reg[0] == '0);
    assign stat.next_due  = (occ_reg > OCC_W'(1)) && (rem_reg[1] == '0);
    assign stat.full      = (occ_reg == OCC_W'(DEPTH));
    assign stat.any_match = |match;

    assign strobe        = strobe_reg;
    assign kind          = kind_reg;
    assign event_id_res  = res_id_reg;
    assign removed_count = removed_out_reg;
    assign pending_count = pending_reg;
    assign last          = last_reg;

endmodule

[tb/sv/tb_sorted_timer_event_queue_unit.sv]
module tb_sorted_timer_event_queue_unit;
    import steq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 340;
    localparam int TAIL_CYCLES  = 2 * DEPTH + 8;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [PORT_ID_W-1:0] ident;
        logic [CNT_W-1:0]     removed;
        logic [CNT_W-1:0]     pending;
        logic                 last;
    } queue_report_t;

    // Queue model plus the reports it still owes
    class timer_queue_checker;
        logic [ID_BITS-1:0]   ident_q[DEPTH];
        logic [TICK_BITS-1:0] remain_q[DEPTH];
        int                   occ;
        queue_report_t        awaited[$];
        int                   errors;
        int                   commands_seen[4];
        int                   kinds_seen[4];

        function new();
            occ    = 0;
            errors = 0;
            foreach (commands_seen[k]) commands_seen[k] = 0;
            foreach (kinds_seen[k]) kinds_seen[k] = 0;
        endfunction

        function void owe(logic [KIND_W-1:0] k, logic [ID_BITS-1:0] id,
                          int removed, logic is_last);
            queue_report_t r;
            r.kind    = k;
            r.ident   = PORT_ID_W'(id);
            r.removed = CNT_W'(removed);
            r.pending = CNT_W'(occ);
            r.last    = is_last;
            awaited.push_back(r);
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [PORT_ID_W-1:0] id_in,
                                   logic [TICK_BITS-1:0] dly_in);
            logic [ID_BITS-1:0]   id;
            logic [TICK_BITS-1:0] dly;
            logic [ID_BITS-1:0]   due_id;
            int                   i;
            int                   kept;
            id  = id_in[ID_BITS-1:0];
            dly = dly_in;
            commands_seen[cmd]++;
            case (cmd)
                CMD_TICK:
                begin
                    for (i = 0; i < occ; i++)
                        if (remain_q[i] != 0) remain_q[i]--;
                    while (occ > 0 && remain_q[0] == 0)
                    begin
                        due_id = ident_q[0];
                        for (i = 1; i < occ; i++)
                        begin
                            ident_q[i-1]  = ident_q[i];
                            remain_q[i-1] = remain_q[i];
                        end
                        occ--;
                        owe(KIND_DUE, due_id, 0, !(occ > 0 && remain_q[0] == 0));
                    end
                end
                CMD_SCHEDULE:
                begin
                    // one tick off, floor of one tick
                    if (dly >= 1) dly--;
                    if (dly == 0) dly = 1;
                    if (occ >= DEPTH)
                    begin
                        owe(KIND_REJECTED, id, 0, 1'b1);
                    end
                    else
                    begin
                        i = occ;
                        while (i > 0 && remain_q[i-1] > dly)
                        begin
                            ident_q[i]  = ident_q[i-1];
                            remain_q[i] = remain_q[i-1];
                            i--;
                        end
                        ident_q[i]  = id;
                        remain_q[i] = dly;
                        occ++;
                        owe(KIND_SCHEDULED, id, 0, 1'b1);
                    end
                end
                CMD_CANCEL:
                begin
                    kept = 0;
                    for (i = 0; i < occ; i++)
                    begin
                        if (ident_q[i] != id)
                        begin
                            ident_q[kept]  = ident_q[i];
                            remain_q[kept] = remain_q[i];
                            kept++;
                        end
                    end
                    i   = occ - kept;
                    occ = kept;
                    owe(KIND_CANCELLED, id, i, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [KIND_W-1:0] k, logic [PORT_ID_W-1:0] id,
                                   logic [CNT_W-1:0] removed, logic [CNT_W-1:0] pending,
                                   logic is_last);
            queue_report_t exp;
            kinds_seen[k]++;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: kind %0d id %0d", k, id);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (k !== exp.kind)
            begin
                $error("kind: expected %0d, actual %0d", exp.kind, k);
                errors++;
            end
            if (id !== exp.ident)
            begin
                $error("event_id_res: expected %0d, actual %0d", exp.ident, id);
                errors++;
            end
            if (removed !== exp.removed)
            begin
                $error("removed_count: expected %0d, actual %0d", exp.removed, removed);
                errors++;
            end
            if (pending !== exp.pending)
            begin
                $error("pending_count: expected %0d, actual %0d", exp.pending, pending);
                errors++;
            end
            if (is_last !== exp.last)
            begin
                $error("last: expected %0d, actual %0d", exp.last, is_last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     command;
    logic [PORT_ID_W-1:0] event_id;
    logic [TICK_BITS-1:0] delay_ticks;
    logic                 strobe;
    logic [KIND_W-1:0]    kind;
    logic [PORT_ID_W-1:0] event_id_res;
    logic [CNT_W-1:0]     removed_count;
    logic [CNT_W-1:0]     pending_count;
    logic                 last;

    timer_queue_checker   chk;
    int                   cycle_count;
    bit                   burst_mode;

    sorted_timer_event_queue_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .event_id      (event_id),
        .delay_ticks   (delay_ticks),
        .strobe        (strobe),
        .kind          (kind),
        .event_id_res  (event_id_res),
        .removed_count (removed_count),
        .pending_count (pending_count),
        .last          (last)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // results first, then the transfer of this edge, so order within the step is fixed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
                chk.check_result(kind, event_id_res, removed_count, pending_count, last);
            if (start && !busy)
                chk.note_command(command, event_id, delay_ticks);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap();
        if (burst_mode)
            return 0;
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [PORT_ID_W-1:0] pick_ident();
        // small pool so cancels hit repeated identifiers
        if ($urandom_range(0, 9) < 8)
            return PORT_ID_W'($urandom_range(0, 7));
        return PORT_ID_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [TICK_BITS-1:0] pick_delay();
        int p;
        p = $urandom_range(0, 19);
        if (p < 15)
            return TICK_BITS'($urandom_range(0, 6));
        if (p < 18)
            return TICK_BITS'($urandom_range(7, 40));
        return TICK_BITS'($urandom);
    endfunction

    // holds start until the transfer; start is only lowered when a gap follows
    task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                 input logic [PORT_ID_W-1:0] id,
                                 input logic [TICK_BITS-1:0] dly, input int gap);
        start       <= 1'b1;
        command     <= cmd;
        event_id    <= id;
        delay_ticks <= dly;
        do
            @(posedge clk);
        while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_directed();
        issue_command(CMD_TICK,     8'h00, 16'h0000, $urandom_range(0, 2));
        issue_command(CMD_SCHEDULE, 8'h00, 16'h0000, $urandom_range(0, 2));
        issue_command(CMD_SCHEDULE, 8'hFF, 16'h0001, $urandom_range(0, 2));
        issue_command(CMD_SCHEDULE, 8'hAA, 16'h0002, $urandom_range(0, 2));
        issue_command(CMD_SCHEDULE, 8'h55, 16'hFFFF, $urandom_range(0, 2));
        issue_command(CMD_SCHEDULE, 8'hAA, 16'h0001, $urandom_range(0, 2));
        issue_command(CMD_SCHEDULE, 8'h7F, 16'h8000, $urandom_range(0, 2));
        issue_command(CMD_SCHEDULE, 8'h80, 16'h0003, $urandom_range(0, 2));
        issue_command(CMD_SCHEDULE, 8'h01, 16'h7FFF, $urandom_range(0, 2));
        // queue now full
        issue_command(CMD_SCHEDULE, 8'h11, 16'h0005, $urandom_range(0, 2));
        issue_command(CMD_CANCEL,   8'h33, 16'h0000, $urandom_range(0, 2));
        issue_command(CMD_CANCEL,   8'hAA, 16'h0000, $urandom_range(0, 2));
        issue_command(CMD_UNUSED,   8'hFF, 16'hFFFF, $urandom_range(0, 2));
        issue_command(CMD_TICK,     8'h00, 16'h0000, $urandom_range(0, 2));
        issue_command(CMD_TICK,     8'h00, 16'h0000, $urandom_range(0, 2));
        issue_command(CMD_TICK,     8'h00, 16'h0000, $urandom_range(0, 2));
        issue_command(CMD_CANCEL,   8'h55, 16'h0000, $urandom_range(0, 2));
        issue_command(CMD_CANCEL,   8'h7F, 16'h0000, $urandom_range(0, 2));
        issue_command(CMD_CANCEL,   8'h01, 16'h0000, $urandom_range(0, 2));
        issue_command(CMD_CANCEL,   8'h00, 16'h0000, $urandom_range(0, 2));
    endtask

    task automatic run_random();
        int counted;
        int r;
        counted    = 0;
        burst_mode = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 39) == 0)
                burst_mode = ~burst_mode;
            r = $urandom_range(0, 99);
            if (r < 5)
                issue_command(CMD_UNUSED, PORT_ID_W'($urandom_range(0, 255)),
                              TICK_BITS'($urandom), pick_gap());
            else if (r < 45)
                issue_command(CMD_SCHEDULE, pick_ident(), pick_delay(), pick_gap());
            else if (r < 80)
                issue_command(CMD_TICK, PORT_ID_W'($urandom_range(0, 255)),
                              TICK_BITS'($urandom), pick_gap());
            else
                issue_command(CMD_CANCEL, pick_ident(), TICK_BITS'($urandom), pick_gap());
            counted++;
        end
    endtask

    initial
    begin
        chk         = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = CMD_TICK;
        event_id    = '0;
        delay_ticks = '0;
        burst_mode  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();
        start <= 1'b0;

        while (chk.awaited.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Commands: %0d tick, %0d schedule, %0d cancel, %0d ignored",
                 chk.commands_seen[CMD_TICK], chk.commands_seen[CMD_SCHEDULE],
                 chk.commands_seen[CMD_CANCEL], chk.commands_seen[CMD_UNUSED]);
        $display("Results: %0d scheduled, %0d rejected, %0d cancel reports, %0d due",
                 chk.kinds_seen[KIND_SCHEDULED], chk.kinds_seen[KIND_REJECTED],
                 chk.kinds_seen[KIND_CANCELLED], chk.kinds_seen[KIND_DUE]);
        if (chk.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
